// File: rtl/cibrp_pkg.sv
// Shared types, constants and a helper function for the CAN identifier byte-range profiler.
package cibrp_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 160;

    localparam int          IN_DATA_W     = 112;
    localparam int          OUT_DATA_W    = 288;
    localparam int          OUT_USER_W    = 3;
    localparam int          BYTE_COUNT    = 8;
    localparam logic [3:0]  MAX_LENGTH    = 4'd8;
    localparam logic [7:0]  BYTE_LOW_INIT = 8'hFF;
    localparam logic [7:0]  BYTE_HIGH_INIT = 8'h00;

    typedef enum logic [2:0] {
        ST_UPDATED     = 3'd0,
        ST_INSERTED    = 3'd1,
        ST_FULL        = 3'd2,
        ST_REMOTE      = 3'd3,
        ST_READ_OK     = 3'd4,
        ST_READ_UNUSED = 3'd5
    } status_t;

    // One table entry as stored in the RAM.
    typedef struct packed {
        logic [28:0] key_id;
        logic        key_ext;
        logic [3:0]  length;
        logic [31:0] count;
        logic [63:0] latest;
        logic [63:0] low;
        logic [63:0] high;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Bit b set when byte b lies below len and its high and low values differ.
    function automatic logic [7:0] moved_mask(input logic [63:0] low,
                                              input logic [63:0] high,
                                              input logic [3:0]  len);
        logic [7:0] m;
        m = '0;
        for (int b = 0; b < BYTE_COUNT; b++) begin
            m[b] = (4'(b) < len) && (low[8*b +: 8] != high[8*b +: 8]);
        end
        return m;
    endfunction

endpackage

// File: rtl/cibrp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cibrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/can_id_byte_range_profiler.sv
// Top level of the CAN identifier byte-range profiler: sequencer, search and byte update.
//
// Channel  | Dir | Handshake                     | Payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser: func; tdata: frame fields, read_index
// m_axis   | out | m_axis_tvalid / m_axis_tready | tuser: status; tdata: entry fields
//
// One transaction at a time. For a profiled frame the linear key search streams one RAM read
// per cycle over the filled entries, then one shared byte compare unit updates one data byte
// per cycle. Reset clears the fill count and the sequencer; the table RAM is never cleared,
// only filled entries are read. A waiting result sits in the output register while the next
// transaction is taken; the sequencer stalls only when it must hand over a result and that
// is still held.
module can_id_byte_range_profiler
    import cibrp_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, lowest bit up: frame_id[28:0], extended[29], remote_frame[30],
    // length_code[34:31], payload[98:35], read_index[106:99], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: func[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, lowest bit up: entry_index[7:0], entry_id[36:8], entry_extended[37],
    // entry_length[41:38], hit_count[73:42], current_bytes[137:74], low_bytes[201:138],
    // high_bytes[265:202], moved_mask[273:266], entries_used[281:274], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IXW8  = (IDX_W > 8) ? IDX_W : 8;
    localparam int CNW8  = (CNT_W > 8) ? CNT_W : 8;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SEARCH   = 7'b0000010,
        S_UPDATE   = 7'b0000100,
        S_WRITE    = 7'b0001000,
        S_RD_ISSUE = 7'b0010000,
        S_RD_DATA  = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // control
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] scan_reg;
    logic             pend_reg;
    logic [3:0]       byte_reg;
    logic             out_valid_reg;

    // payload
    logic [28:0]      id_reg;
    logic             ext_reg;
    logic [3:0]       len_reg;
    logic [63:0]      payload_reg;
    logic [7:0]       ridx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [IDX_W-1:0] idx_reg;
    entry_t           ent_reg;
    status_t          res_status_reg;
    logic [7:0]       res_index_reg;
    entry_t           res_entry_reg;
    logic [7:0]       res_mask_reg;
    status_t          out_status_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // input unpacking
    logic        in_func;
    logic [28:0] in_id;
    logic        in_ext;
    logic        in_rtr;
    logic [3:0]  in_len;
    logic [63:0] in_payload;
    logic [7:0]  in_ridx;
    logic [3:0]  in_len_c;
    logic        in_accept;

    assign in_func    = s_axis_tuser;
    assign in_id      = s_axis_tdata[28:0];
    assign in_ext     = s_axis_tdata[29];
    assign in_rtr     = s_axis_tdata[30];
    assign in_len     = s_axis_tdata[34:31];
    assign in_payload = s_axis_tdata[98:35];
    assign in_ridx    = s_axis_tdata[106:99];
    assign in_len_c   = (in_len > MAX_LENGTH) ? MAX_LENGTH : in_len;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // RAM
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    entry_t             rd_entry;
    logic               wr_en;
    entry_t             ent_final;

    assign rd_entry = entry_t'(rd_data);

    logic scan_more;
    logic hit;
    logic table_full;
    logic read_valid;
    logic byte_go;
    logic out_load;
    logic [5:0] bsel;
    logic [7:0] cur_byte;
    logic [IXW8-1:0] idx_wide;
    logic [CNW8-1:0] fill_wide;

    assign scan_more  = (scan_reg < fill_reg);
    assign hit        = pend_reg && (rd_entry.key_id == id_reg) && (rd_entry.key_ext == ext_reg);
    assign table_full = (fill_reg >= CNT_W'(TABLE_DEPTH));
    assign read_valid = (CNW8'(in_ridx) < CNW8'(fill_reg));
    assign byte_go    = (byte_reg < len_reg);
    assign bsel       = {byte_reg[2:0], 3'b000};
    assign cur_byte   = payload_reg[bsel +: 8];
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    assign idx_wide   = IXW8'(idx_reg);
    assign fill_wide  = CNW8'(fill_reg);

    assign rd_en   = ((state_reg == S_SEARCH) && scan_more) || (state_reg == S_RD_ISSUE);
    assign rd_addr = (state_reg == S_RD_ISSUE) ? IDX_W'(ridx_reg) : scan_reg[IDX_W-1:0];
    assign wr_en   = (state_reg == S_WRITE);

    always_comb
    begin
        ent_final        = ent_reg;
        ent_final.length = len_reg;
        ent_final.count  = ent_reg.count + 32'd1;
    end

    cibrp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (ent_final),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (in_func && read_valid) state_next = S_RD_ISSUE;
                    else if (in_func || in_rtr)         state_next = S_DONE;
                    else                                state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                priority if (hit)        state_next = S_UPDATE;
                else if (scan_more)      state_next = S_SEARCH;
                else if (table_full)     state_next = S_DONE;
                else                     state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (!byte_go)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:    state_next = S_DONE;
            S_RD_ISSUE: state_next = S_RD_DATA;
            S_RD_DATA:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            byte_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                scan_reg <= '0;
                pend_reg <= 1'b0;
            end
            if (state_reg == S_SEARCH)
            begin
                pend_reg <= scan_more;
                if (scan_more)
                begin
                    scan_reg <= scan_reg + CNT_W'(1);
                end
                byte_reg <= '0;
                // claim the next free entry on a miss
                if (!hit && !scan_more && !table_full)
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
            if ((state_reg == S_UPDATE) && byte_go)
            begin
                byte_reg <= byte_reg + 4'd1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            id_reg         <= in_id;
            ext_reg        <= in_ext;
            len_reg        <= in_len_c;
            payload_reg    <= in_payload;
            ridx_reg       <= in_ridx;
            res_entry_reg  <= '0;
            res_mask_reg   <= '0;
            res_index_reg  <= in_func ? in_ridx : 8'd0;
            res_status_reg <= in_func ? ST_READ_UNUSED : (in_rtr ? ST_REMOTE : ST_UPDATED);
        end

        unique case (state_reg)
            S_SEARCH:
            begin
                cmp_idx_reg <= scan_reg[IDX_W-1:0];
                priority if (hit)
                begin
                    ent_reg        <= rd_entry;
                    idx_reg        <= cmp_idx_reg;
                    res_status_reg <= ST_UPDATED;
                end
                else if (!scan_more && table_full)
                begin
                    res_status_reg <= ST_FULL;
                end
                else if (!scan_more)
                begin
                    ent_reg.key_id  <= id_reg;
                    ent_reg.key_ext <= ext_reg;
                    ent_reg.length  <= '0;
                    ent_reg.count   <= '0;
                    ent_reg.latest  <= '0;
                    ent_reg.low     <= {BYTE_COUNT{BYTE_LOW_INIT}};
                    ent_reg.high    <= {BYTE_COUNT{BYTE_HIGH_INIT}};
                    idx_reg         <= IDX_W'(fill_reg);
                    res_status_reg  <= ST_INSERTED;
                end
                else
                begin
                    ent_reg <= ent_reg;
                end
            end
            S_UPDATE:
            begin
                // one byte per cycle through the shared compare unit
                if (byte_go)
                begin
                    ent_reg.latest[bsel +: 8] <= cur_byte;
                    if (cur_byte < ent_reg.low[bsel +: 8])
                    begin
                        ent_reg.low[bsel +: 8] <= cur_byte;
                    end
                    if (cur_byte > ent_reg.high[bsel +: 8])
                    begin
                        ent_reg.high[bsel +: 8] <= cur_byte;
                    end
                end
            end
            S_WRITE:
            begin
                res_entry_reg <= ent_final;
                res_index_reg <= idx_wide[7:0];
                res_mask_reg  <= moved_mask(ent_final.low, ent_final.high, ent_final.length);
            end
            S_RD_DATA:
            begin
                res_status_reg <= ST_READ_OK;
                res_entry_reg  <= rd_entry;
                res_index_reg  <= ridx_reg;
                res_mask_reg   <= moved_mask(rd_entry.low, rd_entry.high, rd_entry.length);
            end
            S_IDLE, S_RD_ISSUE, S_DONE:
            begin
                ent_reg <= ent_reg;
            end
            default:
            begin
                ent_reg <= ent_reg;
            end
        endcase

        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= {6'b0, fill_wide[7:0], res_mask_reg,
                               res_entry_reg.high, res_entry_reg.low, res_entry_reg.latest,
                               res_entry_reg.count, res_entry_reg.length,
                               res_entry_reg.key_ext, res_entry_reg.key_id, res_index_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

// File: test/can_profile_checker.sv
// Checker for the CAN identifier byte-range profiler: predicts each result and compares it.
module can_profile_checker
    import cibrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [OUT_USER_W-1:0] m_axis_tuser,
    output int                    mismatch_count,
    output int                    awaited_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = TABLE_DEPTH_DEFAULT;

    typedef struct packed {
        status_t     status;
        logic [7:0]  index;
        logic [28:0] id;
        logic        ext;
        logic [3:0]  length;
        logic [31:0] count;
        logic [63:0] latest;
        logic [63:0] low;
        logic [63:0] high;
        logic [7:0]  moved;
        logic [7:0]  used;
    } entry_report_t;

    entry_t        profile_rows [DEPTH];
    int            rows_filled = 0;
    entry_report_t awaited_reports [$];
    int            mismatches = 0;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: %s mismatch, got %0h, wanted %0h", $time, what, got, want);
    endtask

    function automatic entry_report_t row_report(input status_t st, input int slot);
        entry_report_t r;
        entry_t        row;
        row = profile_rows[slot];
        r = '0;
        r.status = st;
        r.index  = slot[7:0];
        r.id     = row.key_id;
        r.ext    = row.key_ext;
        r.length = row.length;
        r.count  = row.count;
        r.latest = row.latest;
        r.low    = row.low;
        r.high   = row.high;
        for (int b = 0; b < BYTE_COUNT; b++)
            if (b < row.length && row.low[8*b +: 8] != row.high[8*b +: 8])
                r.moved[b] = 1'b1;
        r.used = rows_filled[7:0];
        return r;
    endfunction

    // Apply one accepted transaction to the table copy and return the result it should give.
    function automatic entry_report_t predict_report(input logic rd,
                                                     input logic [IN_DATA_W-1:0] d);
        entry_report_t r;
        logic [28:0]   id;
        logic          ext;
        logic [3:0]    len;
        logic [63:0]   data;
        logic [7:0]    ridx;
        logic [7:0]    v;
        status_t       st;
        int            slot;
        id   = d[28:0];
        ext  = d[29];
        len  = d[34:31];
        data = d[98:35];
        ridx = d[106:99];
        r = '0;
        r.used = rows_filled[7:0];
        if (rd) begin
            if (int'(ridx) < rows_filled)
                return row_report(ST_READ_OK, int'(ridx));
            r.status = ST_READ_UNUSED;
            r.index  = ridx;
            return r;
        end
        if (d[30]) begin
            r.status = ST_REMOTE;
            return r;
        end
        slot = -1;
        for (int i = 0; i < rows_filled; i++)
            if (slot < 0 && profile_rows[i].key_id == id && profile_rows[i].key_ext == ext)
                slot = i;
        st = ST_UPDATED;
        if (slot < 0) begin
            if (rows_filled >= DEPTH) begin
                r.status = ST_FULL;
                return r;
            end
            slot = rows_filled;
            rows_filled++;
            profile_rows[slot] = '{key_id: id, key_ext: ext, length: 4'd0, count: 32'd0,
                                   latest: 64'd0, low: '1, high: '0};
            st = ST_INSERTED;
        end
        if (len > MAX_LENGTH)
            len = MAX_LENGTH;
        profile_rows[slot].length = len;
        profile_rows[slot].count  = profile_rows[slot].count + 32'd1;
        for (int b = 0; b < BYTE_COUNT; b++) begin
            if (b < len) begin
                v = data[8*b +: 8];
                profile_rows[slot].latest[8*b +: 8] = v;
                if (v < profile_rows[slot].low[8*b +: 8])
                    profile_rows[slot].low[8*b +: 8] = v;
                if (v > profile_rows[slot].high[8*b +: 8])
                    profile_rows[slot].high[8*b +: 8] = v;
            end
        end
        return row_report(st, slot);
    endfunction

    always @(posedge clk) begin : watch
        entry_report_t want;
        logic [OUT_DATA_W-1:0] got;
        if (rst_n) begin
            // Results leave strictly in order, so compare before queuing this edge's input.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (awaited_reports.size() == 0) begin
                    flag_mismatch("unawaited result, status", 64'(m_axis_tuser), 64'd0);
                end
                else begin
                    want = awaited_reports.pop_front();
                    if (m_axis_tuser !== want.status)
                        flag_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                    if (got[7:0] !== want.index)
                        flag_mismatch("entry_index", 64'(got[7:0]), 64'(want.index));
                    if (got[36:8] !== want.id)
                        flag_mismatch("entry_id", 64'(got[36:8]), 64'(want.id));
                    if (got[37] !== want.ext)
                        flag_mismatch("entry_extended", 64'(got[37]), 64'(want.ext));
                    if (got[41:38] !== want.length)
                        flag_mismatch("entry_length", 64'(got[41:38]), 64'(want.length));
                    if (got[73:42] !== want.count)
                        flag_mismatch("hit_count", 64'(got[73:42]), 64'(want.count));
                    if (got[137:74] !== want.latest)
                        flag_mismatch("current_bytes", got[137:74], want.latest);
                    if (got[201:138] !== want.low)
                        flag_mismatch("low_bytes", got[201:138], want.low);
                    if (got[265:202] !== want.high)
                        flag_mismatch("high_bytes", got[265:202], want.high);
                    if (got[273:266] !== want.moved)
                        flag_mismatch("moved_mask", 64'(got[273:266]), 64'(want.moved));
                    if (got[281:274] !== want.used)
                        flag_mismatch("entries_used", 64'(got[281:274]), 64'(want.used));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_reports.push_back(predict_report(s_axis_tuser, s_axis_tdata));
        end
        mismatch_count <= mismatches;
        awaited_count  <= awaited_reports.size();
    end

endmodule

// File: test/tb_can_id_byte_range_profiler.sv
// Testbench top for the CAN identifier byte-range profiler: stimulus, flow control and verdict.
module tb_can_id_byte_range_profiler;
    timeunit 1ns;
    timeprecision 1ps;

    import cibrp_pkg::*;

    localparam int POOL_SIZE = 60;
    localparam int RANDOM_ITEMS = 650;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    int                    mismatch_count;
    int                    awaited_count;

    bit steady = 1'b0;
    bit hold_off_request = 1'b0;

    can_id_byte_range_profiler dut (.*);

    can_profile_checker prof_check (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #8ms;
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls, none while steady, and one long hold-off on request.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (800) @(posedge clk);
            end
            else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 34);
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] frame_word(input logic [28:0] id,
                                                        input logic ext,
                                                        input logic rtr,
                                                        input logic [3:0] len,
                                                        input logic [63:0] data,
                                                        input logic [7:0] ridx);
        return {5'd0, ridx, data, len, rtr, ext, id};
    endfunction

    function automatic logic [29:0] random_key();
        logic        ext;
        logic [28:0] id;
        ext = 1'($urandom_range(0, 1));
        id  = 29'($urandom);
        // Standard frames mostly carry 11-bit identifiers.
        if (!ext && $urandom_range(0, 3) != 0)
            id = {18'd0, id[10:0]};
        return {ext, id};
    endfunction

    task automatic send(input logic rd, input logic [IN_DATA_W-1:0] word);
        while (!steady && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rd;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial begin : stimulus
        logic [29:0] key_pool [POOL_SIZE];
        logic [29:0] key;
        logic [3:0]  len;
        logic [63:0] data;
        logic [7:0]  ridx;
        int          pick;

        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= 1'b0;
        s_axis_tdata  <= '0;
        rst_n         <= 1'b0;
        for (int k = 0; k < POOL_SIZE; k++)
            key_pool[k] = random_key();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads of an empty table, remote frame, length extremes, key split by format.
        send(1'b1, frame_word(29'h0, 1'b0, 1'b0, 4'd0, 64'h0, 8'd0));
        send(1'b1, frame_word(29'h1FFFFFFF, 1'b1, 1'b1, 4'hF, '1, 8'd255));
        send(1'b0, frame_word(29'h123, 1'b0, 1'b1, 4'd8, 64'h1122334455667788, 8'd0));
        send(1'b0, frame_word(29'h0, 1'b0, 1'b0, 4'd0, '1, 8'd0));
        send(1'b0, frame_word(29'h1FFFFFFF, 1'b1, 1'b0, 4'd8, '1, 8'hFF));
        send(1'b0, frame_word(29'h1FFFFFFF, 1'b1, 1'b0, 4'd15, 64'h0, 8'd0));
        send(1'b0, frame_word(29'h7FF, 1'b0, 1'b0, 4'd8, 64'h0123456789ABCDEF, 8'd0));
        send(1'b0, frame_word(29'h7FF, 1'b1, 1'b0, 4'd3, 64'h00000000008040C0, 8'd0));
        send(1'b0, frame_word(29'h7FF, 1'b0, 1'b0, 4'd3, '1, 8'd0));
        send(1'b0, frame_word(29'h7FF, 1'b0, 1'b0, 4'd9, 64'h0000FFFF00000001, 8'd0));
        send(1'b0, frame_word(29'h7FF, 1'b0, 1'b1, 4'd8, 64'h0, 8'd0));
        send(1'b0, frame_word(29'h0, 1'b0, 1'b0, 4'd1, 64'h80, 8'd0));
        send(1'b0, frame_word(29'h0, 1'b0, 1'b0, 4'd2, 64'h7F7F, 8'd0));
        for (int k = 0; k < 5; k++)
            send(1'b1, frame_word(29'h0, 1'b0, 1'b0, 4'd0, 64'h0, 8'(k)));
        send(1'b1, frame_word(29'h0, 1'b0, 1'b0, 4'd0, 64'h0, 8'd159));
        send(1'b1, frame_word(29'h0, 1'b0, 1'b0, 4'd0, 64'h0, 8'd160));

        // Random: frames on keys from a fixed pool or fresh keys that overflow the table, plus reads.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 250 && n < 350);
            if (n == 420)
                hold_off_request = 1'b1;
            pick = $urandom_range(99);
            len  = ($urandom_range(0, 3) == 0) ? MAX_LENGTH : 4'($urandom_range(0, 15));
            data = {$urandom, $urandom};
            ridx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 170));
            key  = (pick < 45) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : random_key();
            if (pick < 72)
                send(1'b0, frame_word(key[28:0], key[29], 1'b0, len, data, 8'($urandom)));
            else if (pick < 80)
                send(1'b0, frame_word(key[28:0], key[29], 1'b1, len, data, 8'($urandom)));
            else if (pick < 95)
                send(1'b1, frame_word(key[28:0], key[29], 1'($urandom), len, data, ridx));
            else
                send(1'($urandom), frame_word(29'($urandom), 1'($urandom), 1'($urandom),
                                              4'($urandom), data, 8'($urandom)));
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Let the last acceptance reach the count before waiting on it.
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
